// ===== hdl/gtq_pkg.sv =====
// ----------------------------------------------------------------------------
// gtq_pkg
// Shared types and codes for the grouped team queue.
// ----------------------------------------------------------------------------
package gtq_pkg;

  localparam int ELEM_W   = 10;
  localparam int TEAM_W   = 4;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int NUM_ELEMENTS = 1 << ELEM_W;
  localparam int NUM_TEAMS    = 1 << TEAM_W;

  localparam logic [ACT_W-1:0] ACT_MAP    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENQ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEQ    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // classified request passed from front to back
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ELEM_W-1:0] element;
    logic [TEAM_W-1:0] team;
  } op_t;

  // front status seen by the top level
  typedef struct packed {
    logic clearing;
  } front_stat_t;

endpackage

// ===== hdl/grouped_team_queue.sv =====
// ----------------------------------------------------------------------------
// grouped_team_queue
// Team queue: elements of one team stay together, teams leave in arrival order.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. A map request sets the team of an
// element id; an enqueue joins the element to its team's group, or opens a new
// group at the tail; a dequeue returns the head element, or status empty. An
// enqueue into a full store of CAPACITY entries is dropped with status full.
// After reset the team table is swept to team 0, one id per cycle, so the
// slave side stays not-ready until the sweep ends. After that, an enqueue or
// dequeue in the back end first reads the link and value memories, then
// writes the updated links, heads and tails; maps and rejected requests skip
// the write step. The front end adds a registered team-table lookup and a
// 4-deep queue, so it keeps taking requests while the back end or the
// response register is busy, until the queue and the lookup stage are full.
// ----------------------------------------------------------------------------
module grouped_team_queue #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] action, [11:2] element, [15:12] team
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] status, [11:2] element_out, [15:12] zero
);

  gtq_pkg::op_t        s_op;
  gtq_pkg::op_t        push_op;
  gtq_pkg::op_t        fifo_dout;
  gtq_pkg::front_stat_t front_stat;
  logic                push;
  logic                fifo_full;
  logic                fifo_empty;
  logic                fifo_pop;
  logic [$clog2(CAPACITY+1)-1:0] used_count;

  assign s_op = '{action:  s_tdata[1:0],
                  element: s_tdata[11:2],
                  team:    s_tdata[15:12]};

  // front: handshake, team lookup, map writes
  gtq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_op      (s_op),
    .push      (push),
    .push_op   (push_op),
    .fifo_full (fifo_full),
    .stat      (front_stat)
  );

  gtq_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_op),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .dout  (fifo_dout),
    .empty (fifo_empty)
  );

  // back: linked store, free list, team order ring, response register
  gtq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .fifo_dout  (fifo_dout),
    .fifo_pop   (fifo_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .used_count (used_count)
  );

  // no request enters while the team table is being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    front_stat.clearing |-> !s_tready)
    else $error("request accepted during team table sweep");

  // only a successful dequeue carries an element
  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != gtq_pkg::ST_DONE) |-> (m_tdata[11:2] == '0))
    else $error("element on a non-done response");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= ($clog2(CAPACITY+1))'(CAPACITY))
    else $error("entry count above capacity");

  // the back end only pops the queue when it holds a request
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_empty)
    else $error("pop from empty queue");

endmodule

// ===== hdl/gtq_front.sv =====
// ----------------------------------------------------------------------------
// gtq_front
// Accepts requests, owns the team table, looks up the team of enqueues.
// ----------------------------------------------------------------------------
module gtq_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  gtq_pkg::op_t        s_op,
  output logic                push,
  output gtq_pkg::op_t        push_op,
  input  logic                fifo_full,
  output gtq_pkg::front_stat_t stat
);

  logic [gtq_pkg::TEAM_W-1:0] team_mem [gtq_pkg::NUM_ELEMENTS];
  logic [gtq_pkg::ELEM_W-1:0] clr_addr;
  logic                       clearing;
  logic                       stage_valid;
  logic [gtq_pkg::ACT_W-1:0]  stage_act;
  logic [gtq_pkg::ELEM_W-1:0] stage_elem;
  logic [gtq_pkg::TEAM_W-1:0] team_rd;
  logic                       accept;

  assign s_tready = !clearing && !(stage_valid && fifo_full);
  assign accept   = s_tvalid && s_tready;
  assign push     = stage_valid && !fifo_full;
  assign push_op  = '{action: stage_act, element: stage_elem, team: team_rd};
  assign stat.clearing = clearing;

  // clear sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == gtq_pkg::ELEM_W'(gtq_pkg::NUM_ELEMENTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      team_mem[clr_addr] <= '0;
    end else if (accept && s_op.action == gtq_pkg::ACT_MAP) begin
      team_mem[s_op.element] <= s_op.team;
    end
    if (accept) begin
      team_rd <= team_mem[s_op.element];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_act  <= s_op.action;
      stage_elem <= s_op.element;
    end
  end

endmodule

// ===== hdl/gtq_fifo.sv =====
// ----------------------------------------------------------------------------
// gtq_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module gtq_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  gtq_pkg::op_t din,
  output logic         full,
  input  logic         pop,
  output gtq_pkg::op_t dout,
  output logic         empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  gtq_pkg::op_t       mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

// ===== hdl/gtq_back.sv =====
// ----------------------------------------------------------------------------
// gtq_back
// Executes requests on the linked entry store and team order ring.
// ----------------------------------------------------------------------------
module gtq_back #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fifo_empty,
  input  gtq_pkg::op_t                  fifo_dout,
  output logic                          fifo_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,
  output logic [$clog2(CAPACITY+1)-1:0] used_count
);

  localparam int CAP_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int TW    = gtq_pkg::TEAM_W;
  localparam int EW    = gtq_pkg::ELEM_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  logic [EW-1:0]    val_mem  [CAPACITY];
  logic [CAP_W-1:0] link_mem [CAPACITY];
  logic [CAP_W-1:0] team_head [gtq_pkg::NUM_TEAMS];
  logic [CAP_W-1:0] team_tail [gtq_pkg::NUM_TEAMS];
  logic [TW-1:0]    team_order [gtq_pkg::NUM_TEAMS];
  logic [gtq_pkg::NUM_TEAMS-1:0] team_present;
  logic [TW-1:0]    order_head;
  logic [TW-1:0]    order_tail;
  logic [CAP_W-1:0] free_head;
  logic [CNT_W-1:0] fresh_cnt;

  logic [gtq_pkg::ACT_W-1:0] op_act;
  logic [EW-1:0]    op_elem;
  logic [TW-1:0]    t_d;
  logic [CAP_W-1:0] idx_d;
  logic [CAP_W-1:0] link_rd;
  logic [EW-1:0]    val_rd;
  logic [gtq_pkg::STAT_W-1:0] out_status;
  logic [EW-1:0]    out_elem;

  logic             go;
  logic             is_enq;
  logic             is_deq;
  logic [TW-1:0]    deq_t;
  logic [CAP_W-1:0] deq_idx;
  logic [CAP_W-1:0] rd_addr;
  logic             fresh;
  logic [CAP_W-1:0] fresh_next;
  logic             exec_enq;
  logic             exec_deq;
  logic             link_we;
  logic [CAP_W-1:0] link_waddr;
  logic [CAP_W-1:0] link_wdata;

  assign go       = (state == S_IDLE) && !fifo_empty && (!m_tvalid || m_tready);
  assign fifo_pop = go;
  assign is_enq   = (fifo_dout.action == gtq_pkg::ACT_ENQ) &&
                    (used_count < CNT_W'(CAPACITY));
  assign is_deq   = (fifo_dout.action == gtq_pkg::ACT_DEQ) && (used_count != '0);
  assign deq_t    = team_order[order_head];
  assign deq_idx  = team_head[deq_t];
  assign rd_addr  = (fifo_dout.action == gtq_pkg::ACT_ENQ) ? free_head : deq_idx;

  assign exec_enq = (state == S_EXEC) && (op_act == gtq_pkg::ACT_ENQ);
  assign exec_deq = (state == S_EXEC) && (op_act == gtq_pkg::ACT_DEQ);

  // entries never handed out yet sit in index order behind the recycled ones
  assign fresh      = (fresh_cnt < CNT_W'(CAPACITY)) && (CNT_W'(free_head) == fresh_cnt);
  assign fresh_next = (free_head == CAP_W'(CAPACITY - 1)) ? '0 : free_head + 1'b1;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = idx_d;
    link_wdata = free_head;
    if (exec_enq && team_present[t_d]) begin
      link_we    = 1'b1;
      link_waddr = team_tail[t_d];
      link_wdata = idx_d;
    end else if (exec_deq) begin
      link_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      link_rd <= link_mem[rd_addr];
      val_rd  <= val_mem[rd_addr];
    end
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (exec_enq) val_mem[idx_d] <= op_elem;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      op_act  <= fifo_dout.action;
      op_elem <= fifo_dout.element;
      if (fifo_dout.action == gtq_pkg::ACT_ENQ) begin
        t_d   <= fifo_dout.team;
        idx_d <= free_head;
      end else begin
        t_d   <= deq_t;
        idx_d <= deq_idx;
      end
    end
    if (exec_enq && !team_present[t_d]) begin
      team_head[t_d]         <= idx_d;
      team_order[order_tail] <= t_d;
    end
    if (exec_enq) team_tail[t_d] <= idx_d;
    if (exec_deq && idx_d != team_tail[t_d]) team_head[t_d] <= link_rd;
    if (state == S_EXEC) begin
      out_status <= gtq_pkg::ST_DONE;
      out_elem   <= (op_act == gtq_pkg::ACT_DEQ) ? val_rd : '0;
    end else if (go && !(is_enq || is_deq)) begin
      out_elem <= '0;
      case (fifo_dout.action)
        gtq_pkg::ACT_ENQ: out_status <= gtq_pkg::ST_FULL;
        gtq_pkg::ACT_DEQ: out_status <= gtq_pkg::ST_EMPTY;
        default:          out_status <= gtq_pkg::ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      team_present <= '0;
      order_head   <= '0;
      order_tail   <= '0;
      free_head    <= '0;
      fresh_cnt    <= '0;
      used_count   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (go && !(is_enq || is_deq)) begin
            m_tvalid <= 1'b1;
          end else if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (go && (is_enq || is_deq)) state <= S_EXEC;
        end
        S_EXEC: begin
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
          if (op_act == gtq_pkg::ACT_ENQ) begin
            if (fresh) begin
              free_head <= fresh_next;
              fresh_cnt <= fresh_cnt + 1'b1;
            end else begin
              free_head <= link_rd;
            end
            if (!team_present[t_d]) begin
              team_present[t_d] <= 1'b1;
              order_tail        <= order_tail + 1'b1;
            end
            used_count <= used_count + 1'b1;
          end else begin
            if (idx_d == team_tail[t_d]) begin
              team_present[t_d] <= 1'b0;
              order_head        <= order_head + 1'b1;
            end
            free_head  <= idx_d;
            used_count <= used_count - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'b0, out_elem, out_status};

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grouped team queue: directed and random
// map/enqueue/dequeue requests checked against an in-bench team queue model.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  always #5 clk = ~clk;

  grouped_team_queue #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Team queue model: the team table plus one fifo of element ids per team,
  // and the order in which teams opened their groups.
  logic [gtq_pkg::TEAM_W-1:0] team_map [gtq_pkg::NUM_ELEMENTS];
  logic [gtq_pkg::ELEM_W-1:0] group_q [gtq_pkg::NUM_TEAMS][$];
  logic [gtq_pkg::TEAM_W-1:0] team_line [$];
  int                queued_cnt;

  // expected responses, {status, element_out}
  logic [gtq_pkg::STAT_W+gtq_pkg::ELEM_W-1:0] resp_q [$];

  int  errors = 0;
  int  sent = 0;
  int  checked = 0;
  int  deq_hits = 0;
  int  full_hits = 0;
  int  empty_hits = 0;
  bit  rx_idle_en = 1'b1;
  bit  tx_idle_en = 1'b1;
  int  rx_hold = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  longint cycles = 0;

  // compute the response of one request and advance the model
  function automatic logic [gtq_pkg::STAT_W+gtq_pkg::ELEM_W-1:0] predict_team_queue(
    logic [gtq_pkg::ACT_W-1:0] act, logic [gtq_pkg::ELEM_W-1:0] el,
    logic [gtq_pkg::TEAM_W-1:0] tm);
    logic [gtq_pkg::TEAM_W-1:0] t;
    logic [gtq_pkg::ELEM_W-1:0] v;
    if (act == gtq_pkg::ACT_MAP) begin
      team_map[el] = tm;
      return {gtq_pkg::ST_DONE, {gtq_pkg::ELEM_W{1'b0}}};
    end else if (act == gtq_pkg::ACT_ENQ) begin
      if (queued_cnt >= CAP) begin
        full_hits++;
        return {gtq_pkg::ST_FULL, {gtq_pkg::ELEM_W{1'b0}}};
      end
      t = team_map[el];
      if (group_q[t].size() == 0) team_line.insert(team_line.size(), t);
      group_q[t].insert(group_q[t].size(), el);
      queued_cnt++;
      return {gtq_pkg::ST_DONE, {gtq_pkg::ELEM_W{1'b0}}};
    end else if (act == gtq_pkg::ACT_DEQ) begin
      if (queued_cnt == 0) begin
        empty_hits++;
        return {gtq_pkg::ST_EMPTY, {gtq_pkg::ELEM_W{1'b0}}};
      end
      t = team_line[0];
      v = group_q[t].pop_front();
      if (group_q[t].size() == 0) void'(team_line.pop_front());
      queued_cnt--;
      deq_hits++;
      return {gtq_pkg::ST_DONE, v};
    end
    // unused action code: no effect
    return {gtq_pkg::ST_DONE, {gtq_pkg::ELEM_W{1'b0}}};
  endfunction

  // sender: hold one request until accepted, with random idle bursts
  task automatic send_request(logic [gtq_pkg::ACT_W-1:0] act,
                              logic [gtq_pkg::ELEM_W-1:0] el,
                              logic [gtq_pkg::TEAM_W-1:0] tm);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tm, el, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    resp_q.insert(resp_q.size(), predict_team_queue(act, el, tm));
    sent++;
  endtask

  // stop offering and wait until every expected response has come
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
  endtask

  // receiver ready: random bursts of stall, or a long forced hold
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      rx_hold   <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      rx_hold  <= $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // response checker
  always @(posedge clk) begin
    logic [gtq_pkg::STAT_W+gtq_pkg::ELEM_W-1:0] exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected response expected none actual %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = resp_q.pop_front();
        checked++;
        if (m_tdata[1:0] !== exp_r[gtq_pkg::STAT_W+gtq_pkg::ELEM_W-1 -: gtq_pkg::STAT_W])
          begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   exp_r[gtq_pkg::STAT_W+gtq_pkg::ELEM_W-1 -: gtq_pkg::STAT_W],
                   m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[11:2] !== exp_r[gtq_pkg::ELEM_W-1:0]) begin
          $display("%0t: element mismatch expected %0d actual %0d", $time,
                   exp_r[gtq_pkg::ELEM_W-1:0], m_tdata[11:2]);
          errors++;
        end
        if (m_tdata[15:12] !== 4'd0) begin
          $display("%0t: pad mismatch expected 0 actual %h", $time, m_tdata[15:12]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // extremes of every field, each action, empty dequeue, remap of a queued id
  task automatic test_directed();
    send_request(gtq_pkg::ACT_DEQ, 10'd0, 4'd0);          // empty queue
    send_request(gtq_pkg::ACT_MAP, 10'd1023, 4'd15);
    send_request(gtq_pkg::ACT_MAP, 10'd0, 4'd0);
    send_request(gtq_pkg::ACT_MAP, 10'd5, 4'd3);
    send_request(gtq_pkg::ACT_ENQ, 10'd0, 4'd0);          // team 0 opens group
    send_request(gtq_pkg::ACT_ENQ, 10'd1023, 4'd0);       // team 15 opens group
    send_request(gtq_pkg::ACT_ENQ, 10'd7, 4'd0);          // unmapped, joins team 0
    send_request(gtq_pkg::ACT_ENQ, 10'd5, 4'd0);          // team 3
    send_request(gtq_pkg::ACT_MAP, 10'd5, 4'd15);         // remap while queued
    send_request(gtq_pkg::ACT_ENQ, 10'd5, 4'd0);          // now joins team 15
    send_request(gtq_pkg::ACT_UNUSED, 10'h3FF, 4'hF);     // unused code
    send_request(gtq_pkg::ACT_DEQ, 10'h3FF, 4'hF);
    send_request(gtq_pkg::ACT_DEQ, 10'd0, 4'd0);
    send_request(gtq_pkg::ACT_DEQ, 10'd0, 4'd0);
    send_request(gtq_pkg::ACT_DEQ, 10'd0, 4'd0);
    send_request(gtq_pkg::ACT_DEQ, 10'd0, 4'd0);
    send_request(gtq_pkg::ACT_DEQ, 10'd0, 4'd0);
    send_request(gtq_pkg::ACT_DEQ, 10'd0, 4'd0);          // empty again
    wait_drained();
  endtask

  // fill past capacity while the receiver holds off, then drain
  task automatic test_full_store();
    int i;
    hold_req = hold_req + 1;
    for (i = 0; i < CAP + 3; i++)
      send_request(gtq_pkg::ACT_ENQ, 10'($urandom_range(0, 1023)), 4'($urandom));
    for (i = 0; i < CAP + 1; i++)
      send_request(gtq_pkg::ACT_DEQ, 10'($urandom), 4'($urandom));
    wait_drained();   // sender pauses until all responses are in
  endtask

  // random mix, weighted so the queue stays mostly non-empty
  task automatic test_random(int n, int nteams);
    int i, r;
    logic [gtq_pkg::ACT_W-1:0] a;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      a = (r < 20) ? gtq_pkg::ACT_MAP : (r < 62) ? gtq_pkg::ACT_ENQ :
          (r < 97) ? gtq_pkg::ACT_DEQ : gtq_pkg::ACT_UNUSED;
      send_request(a, 10'($urandom_range(0, 1023)),
                   4'($urandom_range(0, nteams - 1)));
    end
  endtask

  initial begin
    for (int i = 0; i < gtq_pkg::NUM_ELEMENTS; i++) team_map[i] = '0;
    queued_cnt = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_store();
    test_random(300, 4);
    test_random(300, 16);
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(300, 16);
    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d requests, checked %0d responses.", sent, checked);
    $display("Dequeued %0d elements, %0d empty and %0d full responses.",
             deq_hits, empty_hits, full_hits);
    if (errors == 0 && resp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gtq_pkg.sv
hdl/gtq_front.sv
hdl/gtq_fifo.sv
hdl/gtq_back.sv
hdl/grouped_team_queue.sv
sim/tb_top.sv
